@@ hw/rtl/lr_pkg.sv @@
// shared types and constants of the line rasterizer
package lr_pkg;

    localparam int COORD_W        = 6;
    localparam int COLOR_W        = 24;
    localparam int REG_W          = 7;
    localparam int CFG_IDX_W      = 1;
    localparam int COORD_BITS_DEF = 6;
    localparam int CMD_DEPTH      = 2;

    localparam logic [REG_W-1:0] SURFACE_RESET = 7'd64;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SURFACE_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_SURFACE_HEIGHT = 1'b1;

    typedef struct packed {
        logic [COORD_W-1:0] start_x;
        logic [COORD_W-1:0] start_y;
        logic [COORD_W-1:0] end_x;
        logic [COORD_W-1:0] end_y;
        logic [COLOR_W-1:0] pixel_color;
    } t_line_cmd;

    typedef struct packed {
        logic [COORD_W-1:0] pixel_x;
        logic [COORD_W-1:0] pixel_y;
        logic [COLOR_W-1:0] point_color;
        logic               on_surface;
        logic               last_point;
    } t_point;

    // classified line, as queued between front and walker
    typedef struct packed {
        logic [COORD_W-1:0] start_x;
        logic [COORD_W-1:0] start_y;
        logic [COORD_W-1:0] end_x;
        logic [COORD_W-1:0] end_y;
        logic [COORD_W-1:0] delta_x;
        logic [COORD_W-1:0] delta_y;
        logic               step_x_neg;
        logic               step_y_neg;
        logic [COLOR_W-1:0] color;
    } t_walk_cmd;

    typedef struct packed {
        logic [REG_W-1:0] width;
        logic [REG_W-1:0] height;
    } t_surface;

endpackage

@@ hw/rtl/lr_front.sv @@
// front end: takes line commands and works out deltas and step directions
module lr_front #(
    parameter int COORD_BITS = lr_pkg::COORD_BITS_DEF
) (
    input  lr_pkg::t_line_cmd i_cmd,
    input  logic              i_push,
    input  logic              i_queue_full,
    output logic              o_wr_en,
    output lr_pkg::t_walk_cmd o_walk
);
    import lr_pkg::*;

    logic [COORD_BITS-1:0] w_sx;
    logic [COORD_BITS-1:0] w_sy;
    logic [COORD_BITS-1:0] w_ex;
    logic [COORD_BITS-1:0] w_ey;
    logic [COORD_BITS-1:0] w_dx;
    logic [COORD_BITS-1:0] w_dy;

    always_comb begin
        w_sx = i_cmd.start_x[COORD_BITS-1:0];
        w_sy = i_cmd.start_y[COORD_BITS-1:0];
        w_ex = i_cmd.end_x[COORD_BITS-1:0];
        w_ey = i_cmd.end_y[COORD_BITS-1:0];
        w_dx = (w_ex > w_sx) ? w_ex - w_sx : w_sx - w_ex;
        w_dy = (w_ey > w_sy) ? w_ey - w_sy : w_sy - w_ey;

        o_walk.start_x    = COORD_W'(w_sx);
        o_walk.start_y    = COORD_W'(w_sy);
        o_walk.end_x      = COORD_W'(w_ex);
        o_walk.end_y      = COORD_W'(w_ey);
        o_walk.delta_x    = COORD_W'(w_dx);
        o_walk.delta_y    = COORD_W'(w_dy);
        o_walk.step_x_neg = !(w_sx < w_ex);
        o_walk.step_y_neg = !(w_sy < w_ey);
        o_walk.color      = i_cmd.pixel_color;
    end

    assign o_wr_en = i_push && !i_queue_full;

endmodule

@@ hw/rtl/lr_cmd_queue.sv @@
// short command queue between the front end and the walker
module lr_cmd_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_wr_en,
    input  lr_pkg::t_walk_cmd i_wr_data,
    input  logic              i_rd_en,
    output logic              o_full,
    output logic              o_valid,
    output lr_pkg::t_walk_cmd o_rd_data
);
    import lr_pkg::*;

    localparam int PTR_W = (CMD_DEPTH > 1) ? $clog2(CMD_DEPTH) : 1;
    localparam int CNT_W = $clog2(CMD_DEPTH + 1);

    t_walk_cmd        r_mem [CMD_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             w_rd;

    assign w_rd      = i_rd_en && (r_count != '0);
    assign o_valid   = (r_count != '0);
    assign o_full    = (r_count == CNT_W'(CMD_DEPTH));
    assign o_rd_data = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[r_wr_ptr] <= i_wr_data;
        end
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_wr_en) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(CMD_DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
            end
            if (w_rd) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(CMD_DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
            end
            if (i_wr_en && !w_rd) begin
                r_count <= r_count + CNT_W'(1);
            end else if (!i_wr_en && w_rd) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

endmodule

@@ hw/rtl/lr_walker.sv @@
// back end: bresenham walker emitting one point per step into an output register
module lr_walker #(
    parameter int COORD_BITS = lr_pkg::COORD_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cmd_valid,
    input  lr_pkg::t_walk_cmd i_cmd,
    output logic              o_cmd_pop,
    input  lr_pkg::t_surface  i_surface,
    input  logic              i_pop,
    output logic              o_empty,
    output lr_pkg::t_point    o_point
);
    import lr_pkg::*;

    localparam int CB = COORD_BITS;
    localparam int EW = COORD_BITS + 3;

    typedef enum logic {
        WALK_IDLE,
        WALK_RUN
    } t_walk_state;

    t_walk_state         r_state;
    logic                r_out_valid;
    t_point              r_out;
    logic [CB-1:0]       r_x;
    logic [CB-1:0]       r_y;
    logic [CB-1:0]       r_end_x;
    logic [CB-1:0]       r_end_y;
    logic [CB-1:0]       r_dx;
    logic [CB-1:0]       r_dy;
    logic                r_neg_x;
    logic                r_neg_y;
    logic signed [EW-1:0] r_e;
    logic [COLOR_W-1:0]  r_color;

    logic                w_load;
    logic                w_advance;
    logic                w_done;
    logic                w_step_x;
    logic                w_step_y;
    logic signed [EW:0]  w_e2;
    logic signed [EW:0]  w_ext;
    logic signed [EW:0]  w_dx;
    logic signed [EW:0]  w_dy;
    logic signed [EW:0]  w_sum;

    assign w_load    = (r_state == WALK_IDLE) && i_cmd_valid;
    assign w_advance = (r_state == WALK_RUN) && (!r_out_valid || i_pop);
    assign o_cmd_pop = w_load;
    assign o_empty   = !r_out_valid;
    assign o_point   = r_out;

    always_comb begin
        w_done   = (r_x == r_end_x) && (r_y == r_end_y);
        w_dx     = $signed((EW+1)'(r_dx));
        w_dy     = $signed((EW+1)'(r_dy));
        w_ext    = (EW+1)'(r_e);
        w_e2     = $signed({r_e, 1'b0});
        w_step_x = (w_e2 > -w_dy);
        w_step_y = (w_e2 < w_dx);
        w_sum    = w_ext - (w_step_x ? w_dy : '0) + (w_step_y ? w_dx : '0);
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_x     <= i_cmd.start_x[CB-1:0];
            r_y     <= i_cmd.start_y[CB-1:0];
            r_end_x <= i_cmd.end_x[CB-1:0];
            r_end_y <= i_cmd.end_y[CB-1:0];
            r_dx    <= i_cmd.delta_x[CB-1:0];
            r_dy    <= i_cmd.delta_y[CB-1:0];
            r_neg_x <= i_cmd.step_x_neg;
            r_neg_y <= i_cmd.step_y_neg;
            r_e     <= EW'(i_cmd.delta_x) - EW'(i_cmd.delta_y);
            r_color <= i_cmd.color;
        end else if (w_advance) begin
            if (w_step_x) begin
                r_x <= r_neg_x ? r_x - CB'(1) : r_x + CB'(1);
            end
            if (w_step_y) begin
                r_y <= r_neg_y ? r_y - CB'(1) : r_y + CB'(1);
            end
            r_e <= w_sum[EW-1:0];
        end
        if (w_advance) begin
            r_out.pixel_x     <= COORD_W'(r_x);
            r_out.pixel_y     <= COORD_W'(r_y);
            r_out.point_color <= r_color;
            r_out.on_surface  <= (REG_W'(r_x) < i_surface.width)
                              && (REG_W'(r_y) < i_surface.height);
            r_out.last_point  <= w_done;
        end
        if (!i_rst_n) begin
            r_state     <= WALK_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            // a new point fills the slot in the same cycle the old one transfers
            if (w_advance) begin
                r_out_valid <= 1'b1;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                WALK_IDLE: begin
                    if (i_cmd_valid) begin
                        r_state <= WALK_RUN;
                    end
                end
                WALK_RUN: begin
                    if (w_advance && w_done) begin
                        r_state <= WALK_IDLE;
                    end
                end
                default: begin
                    r_state <= WALK_IDLE;
                end
            endcase
        end
    end

endmodule

@@ hw/rtl/line_rasterizer.sv @@
// top level of the bresenham line rasterizer
// A line command (start, end, color) is pushed into a two-entry command queue and walked by the
// Bresenham stepper, which emits every point from start to end inclusive, one point per cycle
// while results are popped; on_surface compares each point with the surface width and height
// registers and last_point marks the end point. A line has n = max(|dx|,|dy|) + 1 points, so up
// to 2^COORD_BITS points; the single walker returns to idle to load the next command after the
// end point of a line. Surface registers may be written only while no line is in flight.
module line_rasterizer #(
    parameter int COORD_BITS = lr_pkg::COORD_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         push,
    output logic                         full,
    input  lr_pkg::t_line_cmd            i_cmd,
    input  logic                         pop,
    output logic                         empty,
    output lr_pkg::t_point               o_point,
    input  logic                         i_cfg_wr,
    input  logic [lr_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [lr_pkg::REG_W-1:0]     i_cfg_data
);
    import lr_pkg::*;

    t_surface  r_surface;
    t_walk_cmd w_front_cmd;
    t_walk_cmd w_queue_cmd;
    logic      w_wr_en;
    logic      w_queue_valid;
    logic      w_queue_pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_surface.width  <= SURFACE_RESET;
            r_surface.height <= SURFACE_RESET;
        end else if (i_cfg_wr) begin
            unique case (i_cfg_idx)
                CFG_SURFACE_WIDTH:  r_surface.width  <= i_cfg_data;
                CFG_SURFACE_HEIGHT: r_surface.height <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    lr_front #(
        .COORD_BITS(COORD_BITS)
    ) u_front (
        .i_cmd       (i_cmd),
        .i_push      (push),
        .i_queue_full(full),
        .o_wr_en     (w_wr_en),
        .o_walk      (w_front_cmd)
    );

    lr_cmd_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_wr_en  (w_wr_en),
        .i_wr_data(w_front_cmd),
        .i_rd_en  (w_queue_pop),
        .o_full   (full),
        .o_valid  (w_queue_valid),
        .o_rd_data(w_queue_cmd)
    );

    lr_walker #(
        .COORD_BITS(COORD_BITS)
    ) u_walker (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd_valid(w_queue_valid),
        .i_cmd      (w_queue_cmd),
        .o_cmd_pop  (w_queue_pop),
        .i_surface  (r_surface),
        .i_pop      (pop),
        .o_empty    (empty),
        .o_point    (o_point)
    );

`ifndef SYNTHESIS
    // the walker keeps the slot filled until the end point has transferred
    a_run_continues: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pop && !empty && !o_point.last_point) |=> !empty)
        else $error("result missing in the middle of a line");

    a_color_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pop && !empty && !o_point.last_point) |=> $stable(o_point.point_color))
        else $error("color changed within a line");

    a_x_adjacent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pop && !empty && !o_point.last_point) |=>
        (o_point.pixel_x == $past(o_point.pixel_x)
         || o_point.pixel_x == $past(o_point.pixel_x) + 6'd1
         || o_point.pixel_x == $past(o_point.pixel_x) - 6'd1))
        else $error("column jumped by more than one");

    a_y_adjacent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pop && !empty && !o_point.last_point) |=>
        (o_point.pixel_y == $past(o_point.pixel_y)
         || o_point.pixel_y == $past(o_point.pixel_y) + 6'd1
         || o_point.pixel_y == $past(o_point.pixel_y) - 6'd1))
        else $error("row jumped by more than one");
`endif

endmodule
